>>> sv/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types and constants of the charge spectrum block
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int NumSamples = 512;
  localparam int NumBins    = 1024;
  localparam int SampleBits = 16;
  localparam int SidxW      = $clog2(NumSamples) + 1;
  localparam int AddrW      = $clog2(NumSamples);
  localparam int BinW       = $clog2(NumBins);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_EOE    = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    FILL_IN    = 2'd0,
    FILL_UNDER = 2'd1,
    FILL_OVER  = 2'd2,
    FILL_NONE  = 2'd3
  } fill_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WSTART = 3'd1,
    REG_WSTOP  = 3'd2,
    REG_CUTLO  = 3'd3,
    REG_CUTHI  = 3'd4,
    REG_HMIN   = 3'd5,
    REG_SHIFT  = 3'd6
  } reg_e;

endpackage

>>> sv/pcs_if.sv
// ----------------------------------------------------------------------------
// pcs_in_if / pcs_out_if
// valid/ready channels of the charge spectrum block
// ----------------------------------------------------------------------------
interface pcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] sample_value;
  logic [8:0]         peak_bin;
  logic signed [15:0] peak_value;
  logic [10:0]        bin_index;
  modport source (output valid, opcode, sample_value, peak_bin, peak_value, bin_index,
                  input ready);
  modport sink   (input valid, opcode, sample_value, peak_bin, peak_value, bin_index,
                  output ready);
endinterface

interface pcs_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic               event_accepted;
  logic [8:0]         timing_bin;
  logic signed [24:0] window_sum;
  logic [1:0]         fill_class;
  logic [31:0]        bin_count;
  modport source (output valid, result_kind, event_accepted, timing_bin, window_sum,
                  fill_class, bin_count, input ready);
  modport sink   (input valid, result_kind, event_accepted, timing_bin, window_sum,
                  fill_class, bin_count, output ready);
endinterface

>>> sv/pulse_charge_spectrum_with_timing_cut.sv
// ----------------------------------------------------------------------------
// pulse_charge_spectrum_with_timing_cut
// waveform store, window sum, timing cut and charge histogram
// ----------------------------------------------------------------------------
// samples take one word per cycle into the waveform ram while the output
// register is free. an end-of-event word in peak mode, or in half-height
// mode with peak_bin zero, passes a judge step and a wait step before the
// next word, with a fill step between them when the sum lands in a
// histogram bin (read, increment, write back). in half-height mode a first
// walk step issues the first waveform read, then the walk back tests one
// waveform entry a cycle until it stops, before the same judge, fill and
// wait steps. a read-bin word does one ram read, then gives the result. a
// clear word sweeps the spectrum ram, one bin a cycle; after reset the same
// clearing pass runs, during which no word is accepted. results wait in an
// output register and the next word is taken only once it is free.
module pulse_charge_spectrum_with_timing_cut
  import pcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pcs_in_if.sink      in_i,
  pcs_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_JUDGE = 7'b0001000,
    ST_FILL  = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic              mode_q;
  logic [9:0]        wstart_q, wstop_q;
  logic [8:0]        cutlo_q, cuthi_q;
  logic signed [24:0] hmin_q;
  logic [4:0]        shift_q;

  assign pready = 1'b1;
  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; wstart_q <= 10'd0; wstop_q <= 10'd512;
      cutlo_q <= 9'd0; cuthi_q <= 9'd511; hmin_q <= '0; shift_q <= '0;
    end else if (wr) begin
      case (reg_e'(paddr[4:2]))
        REG_MODE:   mode_q   <= pwdata[0];
        REG_WSTART: wstart_q <= pwdata[9:0];
        REG_WSTOP:  wstop_q  <= pwdata[9:0];
        REG_CUTLO:  cutlo_q  <= pwdata[8:0];
        REG_CUTHI:  cuthi_q  <= pwdata[8:0];
        REG_HMIN:   hmin_q   <= pwdata[24:0];
        REG_SHIFT:  shift_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_e'(paddr[4:2]))
      REG_MODE:   prdata = {31'd0, mode_q};
      REG_WSTART: prdata = {22'd0, wstart_q};
      REG_WSTOP:  prdata = {22'd0, wstop_q};
      REG_CUTLO:  prdata = {23'd0, cutlo_q};
      REG_CUTHI:  prdata = {23'd0, cuthi_q};
      REG_HMIN:   prdata = {{7{hmin_q[24]}}, hmin_q};
      REG_SHIFT:  prdata = {27'd0, shift_q};
      default:    prdata = '0;
    endcase
  end

  // memories
  logic signed [15:0] wave_mem [NumSamples];
  logic [31:0]        spec_mem [NumBins];
  logic signed [15:0] wave_rd_q;
  logic [31:0]        spec_rd_q;
  logic               wave_we, spec_we;
  logic [AddrW-1:0]   wave_wa, wave_ra;
  logic [BinW-1:0]    spec_wa, spec_ra;
  logic [31:0]        spec_wd;

  always_ff @(posedge clk_i) begin
    if (wave_we) wave_mem[wave_wa] <= in_i.sample_value;
    wave_rd_q <= wave_mem[wave_ra];
  end
  always_ff @(posedge clk_i) begin
    if (spec_we) spec_mem[spec_wa] <= spec_wd;
    spec_rd_q <= spec_mem[spec_ra];
  end

  // datapath state
  logic [SidxW-1:0]   sidx_q, sidx_d;
  logic signed [25:0] acc_q, acc_d;
  logic [31:0]        under_q, under_d, over_q, over_d;
  logic [BinW-1:0]    clr_q, clr_d;
  logic [8:0]         walk_q, walk_d;      // index being tested
  logic signed [15:0] pval_q, pval_d;
  logic               wvalid_q, wvalid_d;  // walk read in flight
  logic [10:0]        ridx_q, ridx_d;
  logic [BinW-1:0]    fbin_q, fbin_d;
  logic               ovalid_q, ovalid_d;
  logic               okind_q, okind_d, oacc_q, oacc_d;
  logic [8:0]         otb_q, otb_d;
  logic signed [24:0] osum_q, osum_d;
  logic [1:0]         ofill_q, ofill_d;
  logic [31:0]        ocnt_q, ocnt_d;

  logic take, in_win, walk_done;
  logic signed [26:0] acc_sum;
  logic signed [24:0] sum_sat;
  logic signed [26:0] diff;
  logic [26:0]        bshift;
  logic               tb_ok;

  assign in_i.ready = (state_q == ST_IDLE) && !ovalid_q;
  assign take = in_i.valid && in_i.ready;
  assign in_win = ({1'b0, sidx_q} >= {1'b0, wstart_q}) && ({1'b0, sidx_q} < {1'b0, wstop_q});
  assign acc_sum = 27'(acc_q) + 27'(in_i.sample_value);
  assign sum_sat = (acc_q > 26'sd16777215) ? 25'sd16777215 :
                   (acc_q < -26'sd16777216) ? -25'sd16777216 : acc_q[24:0];
  assign diff = 27'(sum_sat) - 27'(hmin_q);
  assign bshift = 27'($unsigned(diff) >> shift_q);
  assign tb_ok = (otb_q > cutlo_q) && (otb_q < cuthi_q);
  // stop once 2*sample >= peak, or at bin zero
  assign walk_done = (walk_q == 9'd0) || ((17'(wave_rd_q) <<< 1) >= 17'(pval_q));

  always_comb begin
    state_d = state_q;
    sidx_d = sidx_q; acc_d = acc_q; under_d = under_q; over_d = over_q;
    clr_d = clr_q; walk_d = walk_q; pval_d = pval_q; wvalid_d = 1'b0;
    ridx_d = ridx_q; fbin_d = fbin_q;
    ovalid_d = ovalid_q; okind_d = okind_q; oacc_d = oacc_q; otb_d = otb_q;
    osum_d = osum_q; ofill_d = ofill_q; ocnt_d = ocnt_q;
    wave_we = 1'b0; wave_wa = sidx_q[AddrW-1:0]; wave_ra = walk_q[AddrW-1:0];
    spec_we = 1'b0; spec_wa = clr_q; spec_wd = '0; spec_ra = ridx_q[BinW-1:0];
    if (out_o.ready) ovalid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        spec_we = 1'b1;
        clr_d = clr_q + 1'b1;
        under_d = '0; over_d = '0;
        if (clr_q == BinW'(NumBins - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        spec_ra = in_i.bin_index[BinW-1:0];
        if (take) begin
          case (opcode_e'(in_i.opcode))
            OP_SAMPLE: begin
              if (sidx_q < SidxW'(NumSamples)) begin
                wave_we = 1'b1;
                sidx_d = sidx_q + 1'b1;
                if (in_win) begin
                  acc_d = (acc_sum > 27'sd33554431) ? 26'sd33554431 :
                          (acc_sum < -27'sd33554432) ? -26'sd33554432 : acc_sum[25:0];
                end
              end
            end
            OP_EOE: begin
              pval_d = in_i.peak_value;
              otb_d = in_i.peak_bin;
              if (mode_q && in_i.peak_bin != 9'd0) begin
                walk_d = in_i.peak_bin - 9'd1;
                state_d = ST_WALK;
              end else begin
                state_d = ST_JUDGE;
              end
            end
            OP_READ: begin
              ridx_d = in_i.bin_index;
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              clr_d = '0;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        wvalid_d = 1'b1;
        if (wvalid_q) begin
          if (walk_done) begin
            otb_d = walk_q;
            wvalid_d = 1'b0;
            state_d = ST_JUDGE;
          end else begin
            walk_d = walk_q - 9'd1;
            wave_ra = walk_d[AddrW-1:0];
          end
        end
      end
      ST_JUDGE: begin
        okind_d = 1'b0; oacc_d = tb_ok; osum_d = sum_sat; ocnt_d = '0;
        ofill_d = FILL_NONE;
        sidx_d = '0; acc_d = '0;
        fbin_d = bshift[BinW-1:0];
        state_d = ST_WAIT;
        if (tb_ok) begin
          if (diff < 0) begin
            ofill_d = FILL_UNDER;
            if (under_q != '1) under_d = under_q + 1'b1;
          end else if (bshift >= 27'(NumBins)) begin
            ofill_d = FILL_OVER;
            if (over_q != '1) over_d = over_q + 1'b1;
          end else begin
            ofill_d = FILL_IN;
            spec_ra = bshift[BinW-1:0];
            state_d = ST_FILL;
          end
        end
        if (state_d == ST_WAIT) ovalid_d = 1'b1;
      end
      ST_FILL: begin
        spec_we = 1'b1; spec_wa = fbin_q;
        spec_wd = (spec_rd_q == '1) ? spec_rd_q : spec_rd_q + 1'b1;
        ovalid_d = 1'b1;
        state_d = ST_WAIT;
      end
      ST_READ: begin
        okind_d = 1'b1; oacc_d = 1'b0; otb_d = '0; osum_d = '0; ofill_d = FILL_NONE;
        ocnt_d = (ridx_q < 11'(NumBins)) ? spec_rd_q :
                 (ridx_q == 11'(NumBins)) ? under_q :
                 (ridx_q == 11'(NumBins + 1)) ? over_q : 32'd0;
        ovalid_d = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; sidx_q <= '0; acc_q <= '0; under_q <= '0; over_q <= '0;
      clr_q <= '0; wvalid_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; sidx_q <= sidx_d; acc_q <= acc_d; under_q <= under_d;
      over_q <= over_d; clr_q <= clr_d; wvalid_q <= wvalid_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d; pval_q <= pval_d; ridx_q <= ridx_d; fbin_q <= fbin_d;
    okind_q <= okind_d; oacc_q <= oacc_d; otb_q <= otb_d; osum_q <= osum_d;
    ofill_q <= ofill_d; ocnt_q <= ocnt_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.result_kind = okind_q;
  assign out_o.event_accepted = oacc_q;
  assign out_o.timing_bin = otb_q;
  assign out_o.window_sum = osum_q;
  assign out_o.fill_class = ofill_q;
  assign out_o.bin_count = ocnt_q;

  // assertions
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready) else $error("word taken while busy");
  a_sidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sidx_q <= SidxW'(NumSamples)) else $error("sample index past store");
  a_fill_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |=> ovalid_q) else $error("fill gave no result");
  a_eoe_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_JUDGE) |=> (sidx_q == '0)) else $error("event end left index");

endmodule

>>> tb/pulse_charge_spectrum_with_timing_cut_tb.sv
// ----------------------------------------------------------------------------
// pulse_charge_spectrum_with_timing_cut_tb
// drives sample, end-of-event, read and clear words with random gaps and
// back-pressure, predicts window sum, timing bin, cut and histogram counts in
// a model of its own, and compares every result word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_charge_spectrum_with_timing_cut_tb;
  import pcs_pkg::*;

  // settle time once nothing is expected: covers a clear sweep still running
  localparam int SettleCycles = NumBins + 100;

  typedef struct packed {
    logic               kind;
    logic               accepted;
    logic [8:0]         tbin;
    logic signed [24:0] sum;
    fill_e              fill;
    logic [31:0]        count;
  } spec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pcs_in_if  in_if ();
  pcs_out_if out_if ();

  pulse_charge_spectrum_with_timing_cut uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model state
  logic             mode_q;
  int unsigned      wstart_q, wstop_q, cutlo_q, cuthi_q, shift_q;
  longint           hmin_q;
  logic signed [15:0] wave_mem [NumSamples];
  int unsigned      samp_idx;
  int unsigned      written_cnt;   // entries 0..written_cnt-1 hold a sample since reset
  longint           acc_q;
  logic [31:0]      spectrum [NumBins];
  logic [31:0]      under_cnt, over_cnt;

  spec_word_t       expected_words[$];
  int               fail_cnt;
  int               words_sent;
  bit               quiet;         // no gaps and no stalls while set

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // timing bin of an end-of-event word under the current mode
  function automatic int unsigned timing_of(logic [8:0] pb, logic signed [15:0] pv);
    int unsigned i;
    if (!mode_q || pb == 0) return pb;
    i = pb - 1;
    // rising-edge walk: stay while the sample lies below half the peak
    while (i > 0 && 2 * longint'(wave_mem[i]) < longint'(pv)) i--;
    return i;
  endfunction

  task automatic predict_word(opcode_e op, logic signed [15:0] s, logic [8:0] pb,
                              logic signed [15:0] pv, logic [10:0] bi);
    spec_word_t  w;
    int unsigned t;
    longint      sum, diff, b;
    w = '0;
    w.fill = FILL_NONE;
    case (op)
      OP_SAMPLE: begin
        if (samp_idx < NumSamples) begin
          wave_mem[samp_idx] = s;
          if (samp_idx >= wstart_q && samp_idx < wstop_q) begin
            acc_q += longint'(s);
            if (acc_q > 33554431) acc_q = 33554431;
            if (acc_q < -33554432) acc_q = -33554432;
          end
          samp_idx++;
          if (samp_idx > written_cnt) written_cnt = samp_idx;
        end
      end
      OP_CLEAR: begin
        foreach (spectrum[k]) spectrum[k] = '0;
        under_cnt = '0;
        over_cnt  = '0;
      end
      OP_READ: begin
        w.kind = 1'b1;
        if (bi < NumBins) w.count = spectrum[bi];
        else if (bi == NumBins) w.count = under_cnt;
        else if (bi == NumBins + 1) w.count = over_cnt;
        expected_words.push_back(w);
      end
      default: begin
        t   = timing_of(pb, pv);
        sum = acc_q;
        if (sum > 16777215) sum = 16777215;
        if (sum < -16777216) sum = -16777216;
        w.accepted = (t > cutlo_q) && (t < cuthi_q);
        if (w.accepted) begin
          diff = sum - hmin_q;
          if (diff < 0) begin
            under_cnt = bump(under_cnt);
            w.fill = FILL_UNDER;
          end else begin
            b = diff >> shift_q;
            if (b >= NumBins) begin
              over_cnt = bump(over_cnt);
              w.fill = FILL_OVER;
            end else begin
              spectrum[b] = bump(spectrum[b]);
              w.fill = FILL_IN;
            end
          end
        end
        w.tbin = t[8:0];
        w.sum  = sum[24:0];
        expected_words.push_back(w);
        samp_idx = 0;
        acc_q    = 0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- idling
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure: ready and stall stretches of random length
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
      hold_cnt     <= 0;
    end else if (hold_cnt == 0) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_if.ready <= 1'b1;
        hold_cnt     <= $urandom_range(1, 20);
      end else if (r < 95) begin
        out_if.ready <= 1'b0;
        hold_cnt     <= $urandom_range(1, 3);
      end else begin
        out_if.ready <= 1'b0;
        hold_cnt     <= $urandom_range(10, 40);
      end
    end else begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(opcode_e op, logic signed [15:0] s, logic [8:0] pb,
                           logic signed [15:0] pv, logic [10:0] bi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.sample_value <= s;
    in_if.peak_bin     <= pb;
    in_if.peak_value   <= pv;
    in_if.bin_index    <= bi;
    // ready is stable at the falling edge, the word goes at the next rising one
    do @(negedge clk_i); while (!in_if.ready);
    predict_word(op, s, pb, pv, bi);
    words_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [15:0] s);
    send_word(OP_SAMPLE, s, '0, '0, '0);
  endtask

  task automatic send_eoe(logic [8:0] pb, logic signed [15:0] pv);
    send_word(OP_EOE, '0, pb, pv, '0);
  endtask

  task automatic send_read(logic [10:0] bi);
    send_word(OP_READ, '0, '0, '0, bi);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic m, int unsigned ws, int unsigned we, int unsigned cl,
                           int unsigned ch, longint hm, int unsigned sh);
    wait_idle();
    reg_write(REG_MODE, {31'd0, m});
    reg_write(REG_WSTART, ws);
    reg_write(REG_WSTOP, we);
    reg_write(REG_CUTLO, cl);
    reg_write(REG_CUTHI, ch);
    reg_write(REG_HMIN, hm[31:0]);
    reg_write(REG_SHIFT, sh);
    mode_q = m; wstart_q = ws; wstop_q = we; cutlo_q = cl; cuthi_q = ch;
    hmin_q = hm; shift_q = sh;
  endtask

  // one negative pulse: quiet baseline, a ramp down to the minimum, a slow return, with random stray samples
  task automatic send_pulse_event();
    int          n, p, a, v, pb, r;
    logic signed [15:0] pv;
    r = $urandom_range(0, 99);
    if (r < 2) n = $urandom_range(NumSamples, NumSamples + 12);
    else if (r < 12) n = $urandom_range(0, 3);
    else n = $urandom_range(4, 40);
    p = (n > 0) ? $urandom_range(0, n - 1) : 0;
    a = -$urandom_range(1, 32768);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) v = $signed(16'($urandom()));
      else if (i < p - 5) v = $urandom_range(0, 40) - 20;
      else if (i <= p) v = a * (i - p + 6) / 6;
      else v = a / (i - p + 1);
      send_sample(v[15:0]);
    end
    pb = ($urandom_range(0, 9) < 8) ? p : $urandom_range(0, 511);
    if (pb > 511) pb = 511;
    pv = ($urandom_range(0, 9) < 8) ? a[15:0] : 16'($urandom());
    // the walk must only touch entries written since reset
    if (mode_q && pb > written_cnt) pb = (written_cnt > 511) ? 511 : written_cnt;
    send_eoe(pb[8:0], pv);
  endtask

  task automatic run_traffic(int n_words);
    int target, r;
    target = words_sent + n_words;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 19) == 0);
      if (r < 82) send_pulse_event();
      else if (r < 90) send_read(11'($urandom_range(0, NumBins + 1)));
      else if (r < 93) send_read(11'($urandom()));
      else if (r < 94) send_word(OP_CLEAR, 16'($urandom()), 9'($urandom()),
                                 16'($urandom()), 11'($urandom()));
      else if (r < 97) send_sample(16'($urandom()));
      else begin
        // stray end of event, possibly in the middle of a waveform
        logic [8:0] pb;
        pb = 9'($urandom());
        if (mode_q && pb > written_cnt) pb = (written_cnt > 511) ? 9'd511 : written_cnt[8:0];
        send_eoe(pb, 16'($urandom()));
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      spec_word_t w;
      if (expected_words.size() == 0) begin
        report("unexpected word", {63'd0, out_if.result_kind}, 64'd0);
      end else begin
        w = expected_words.pop_front();
        if (out_if.result_kind !== w.kind) report("result_kind", out_if.result_kind, w.kind);
        if (out_if.event_accepted !== w.accepted)
          report("event_accepted", out_if.event_accepted, w.accepted);
        if (out_if.timing_bin !== w.tbin) report("timing_bin", out_if.timing_bin, w.tbin);
        if (out_if.window_sum !== w.sum) report("window_sum", out_if.window_sum, w.sum);
        if (out_if.fill_class !== w.fill) report("fill_class", out_if.fill_class, w.fill);
        if (out_if.bin_count !== w.count) report("bin_count", out_if.bin_count, w.count);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_readout();
    send_read(11'd0);
    send_read(11'd1023);
    send_read(11'(NumBins));
    send_read(11'(NumBins + 1));
    send_read(11'd2047);
  endtask

  task automatic test_extreme_samples();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_eoe(9'd511, 16'sh8000);     // peak at the top bound, cut rejects it
    send_eoe(9'd0, 16'sh7FFF);       // empty event
    send_sample(16'sd100);
    send_eoe(9'd1, 16'sd0);          // in range bin
    send_word(OP_CLEAR, '0, '0, '0, '0);
    send_read(11'd100);
  endtask

  task automatic test_half_height();
    configure(1'b1, 0, 512, 0, 511, 0, 0);
    send_eoe(9'd0, -16'sd100);       // peak at bin zero: no walk, and no samples in the event
    send_sample(16'sd0);
    send_sample(-16'sd10);
    send_sample(-16'sd100);
    send_sample(-16'sd1000);
    send_sample(-16'sd3000);
    send_eoe(9'd4, -16'sd3000);      // walk stops on the rising edge
    repeat (4) send_sample(-16'sd5000);
    send_eoe(9'd3, -16'sd100);       // walk runs down to bin zero
  endtask

  task automatic test_peak_mode_defaults();
    configure(1'b0, 0, 512, 0, 511, 0, 0);
    run_traffic(220);
  endtask

  task automatic test_short_window_half();
    configure(1'b1, $urandom_range(0, 10), $urandom_range(15, 40), 1, 40, -50000, 8);
    run_traffic(220);
  endtask

  task automatic test_window_closed();
    configure(1'b0, 512, 0, 511, 0, 0, 0);
    run_traffic(100);
  endtask

  task automatic test_wide_bins();
    configure(1'b1, 0, 512, 0, 511, -16777216, 24);
    run_traffic(200);
  endtask

  task automatic test_all_underflow();
    configure(1'b0, 0, 512, 0, 511, 16777215, 0);
    run_traffic(150);
  endtask

  task automatic test_narrow_bins();
    configure(1'b0, 0, 20, $urandom_range(0, 5), $urandom_range(10, 511), -1000, 0);
    run_traffic(220);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      int unsigned ws;
      ws = $urandom_range(0, 30);
      configure(1'($urandom_range(0, 1)), ws, ws + $urandom_range(0, 482),
                $urandom_range(0, 20), $urandom_range(0, 511),
                longint'($urandom_range(0, 33554431)) - 16777216, $urandom_range(0, 24));
      run_traffic(200);
    end
    for (int k = 0; k < 8; k++) send_read(11'(NumBins - 4 + k));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.opcode  <= OP_SAMPLE;
    in_if.sample_value <= '0;
    in_if.peak_bin     <= '0;
    in_if.peak_value   <= '0;
    in_if.bin_index    <= '0;
    quiet         = 1'b0;
    fail_cnt      = 0;
    words_sent    = 0;
    mode_q = 1'b0; wstart_q = 0; wstop_q = 512; cutlo_q = 0; cuthi_q = 511;
    hmin_q = 0; shift_q = 0;
    samp_idx = 0; written_cnt = 0; acc_q = 0;
    under_cnt = '0; over_cnt = '0;
    foreach (spectrum[k]) spectrum[k] = '0;
    foreach (wave_mem[k]) wave_mem[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_readout();
    test_extreme_samples();
    test_half_height();
    test_peak_mode_defaults();
    test_short_window_half();
    test_window_closed();
    test_wide_bins();
    test_all_underflow();
    test_narrow_bins();
    test_random_settings();

    wait_idle();
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/pcs_pkg.sv
sv/pcs_if.sv
sv/pulse_charge_spectrum_with_timing_cut.sv
tb/pulse_charge_spectrum_with_timing_cut_tb.sv
